// File: rtl/sgr_pkg.sv
// Shared types and constants for the sideways glyph rasterizer.
package sgr_pkg;

	localparam int ADDR_W  = 11;
	localparam int COORD_W = 9;
	localparam int SCALE_W = 4;
	localparam int CODE_W  = 8;
	localparam int GW_W    = 4;
	localparam int DATA_W  = 8;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [1:0] REG_GLYPH_WIDTH = 2'd0;
	localparam logic [1:0] REG_FIRST_CODE  = 2'd1;
	localparam logic [1:0] REG_LAST_CODE   = 2'd2;

	localparam logic [GW_W-1:0]   GLYPH_WIDTH_RST = 4'd5;
	localparam logic [CODE_W-1:0] FIRST_CODE_RST  = 8'd32;
	localparam logic [CODE_W-1:0] LAST_CODE_RST   = 8'd126;

	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	localparam logic [2:0] BIT_LAST = 3'd7;

	typedef struct packed {
		logic               action;
		logic [CODE_W-1:0]  char_code;
		logic [7:0]         origin_x;
		logic [7:0]         origin_y;
		logic [SCALE_W-1:0] scale;
		logic [ADDR_W-1:0]  load_address;
		logic [DATA_W-1:0]  load_data;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] square_x;
		logic [COORD_W-1:0] square_y;
		logic [SCALE_W-1:0] square_size;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [GW_W-1:0]   glyph_width;
		logic [CODE_W-1:0] first_code;
		logic [CODE_W-1:0] last_code;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_LOAD,
		ST_READ,
		ST_SCAN,
		ST_FLUSH
	} sgr_state_t;

	typedef struct packed {
		logic capture;
		logic red_step;
		logic mem_write;
		logic mem_read;
		logic scan_adv;
		logic hold_load;
		logic hold_clear;
		logic out_load;
		logic out_last;
	} ctl_cmd_t;

	typedef struct packed {
		logic req_load;
		logic draw_ok;
		logic is_load;
		logic red_last;
		logic bit_set;
		logic bit_last;
		logic cols_more;
		logic hold_valid;
		logic out_free;
	} ctl_sts_t;

endpackage

// File: rtl/sgr_regs.sv
// APB configuration registers: glyph width and code range.
module sgr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sgr_pkg::APB_AW-1:0] paddr,
	input  logic [sgr_pkg::APB_DW-1:0] pwdata,
	output logic [sgr_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output sgr_pkg::cfg_t              cfg
);

	sgr_pkg::cfg_t cfg_q;
	logic [1:0]    reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width <= sgr_pkg::GLYPH_WIDTH_RST;
			cfg_q.first_code  <= sgr_pkg::FIRST_CODE_RST;
			cfg_q.last_code   <= sgr_pkg::LAST_CODE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sgr_pkg::REG_GLYPH_WIDTH: cfg_q.glyph_width <= pwdata[sgr_pkg::GW_W-1:0];
				sgr_pkg::REG_FIRST_CODE:  cfg_q.first_code  <= pwdata[sgr_pkg::CODE_W-1:0];
				sgr_pkg::REG_LAST_CODE:   cfg_q.last_code   <= pwdata[sgr_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			sgr_pkg::REG_GLYPH_WIDTH: prdata = sgr_pkg::APB_DW'(cfg_q.glyph_width);
			sgr_pkg::REG_FIRST_CODE:  prdata = sgr_pkg::APB_DW'(cfg_q.first_code);
			sgr_pkg::REG_LAST_CODE:   prdata = sgr_pkg::APB_DW'(cfg_q.last_code);
			default:                  prdata = '0;
		endcase
	end

endmodule

// File: rtl/sgr_ctrl.sv
// Controller state machine: sequences loads, address reduction and the glyph scan.
module sgr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sgr_pkg::ctl_sts_t sts,
	output sgr_pkg::ctl_cmd_t cmd
);

	sgr_pkg::sgr_state_t state_q;
	sgr_pkg::sgr_state_t state_nxt;
	logic                scan_go;

	// Hold the scan while a new square would overwrite a held one that cannot leave.
	assign scan_go = !(sts.bit_set && sts.hold_valid && !sts.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sgr_pkg::ST_IDLE: begin
				if (req_valid && (sts.req_load || sts.draw_ok)) begin
					state_nxt = sgr_pkg::ST_REDUCE;
				end
			end
			sgr_pkg::ST_REDUCE: begin
				if (sts.red_last) begin
					state_nxt = sts.is_load ? sgr_pkg::ST_LOAD : sgr_pkg::ST_READ;
				end
			end
			sgr_pkg::ST_LOAD: state_nxt = sgr_pkg::ST_IDLE;
			sgr_pkg::ST_READ: state_nxt = sgr_pkg::ST_SCAN;
			sgr_pkg::ST_SCAN: begin
				if (scan_go && sts.bit_last) begin
					state_nxt = sts.cols_more ? sgr_pkg::ST_READ : sgr_pkg::ST_FLUSH;
				end
			end
			sgr_pkg::ST_FLUSH: begin
				if (!sts.hold_valid || sts.out_free) begin
					state_nxt = sgr_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sgr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			sgr_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			sgr_pkg::ST_REDUCE: cmd.red_step  = 1'b1;
			sgr_pkg::ST_LOAD:   cmd.mem_write = 1'b1;
			sgr_pkg::ST_READ:   cmd.mem_read  = 1'b1;
			sgr_pkg::ST_SCAN: begin
				cmd.scan_adv  = scan_go;
				cmd.hold_load = scan_go && sts.bit_set;
				cmd.out_load  = scan_go && sts.bit_set && sts.hold_valid;
			end
			sgr_pkg::ST_FLUSH: begin
				// Drain the held square as the final one of the character.
				cmd.out_load   = sts.hold_valid && sts.out_free;
				cmd.out_last   = 1'b1;
				cmd.hold_clear = sts.hold_valid && sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/sgr_dpath.sv
// Datapath: font memory, address reduction, coordinate stepping and output register.
module sgr_dpath #(
	parameter int FONT_BYTES      = 2048,
	parameter int MAX_GLYPH_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sgr_pkg::ctl_cmd_t  cmd,
	output sgr_pkg::ctl_sts_t  sts,
	input  sgr_pkg::in_item_t  req,
	input  sgr_pkg::cfg_t      cfg,
	output logic               sq_valid,
	input  logic               sq_stall,
	output sgr_pkg::out_item_t sq
);

	function automatic int red_shift(input int f);
		int k;
		k = 0;
		while ((f << (k + 1)) < (1 << sgr_pkg::ADDR_W)) begin
			k = k + 1;
		end
		return k;
	endfunction

	localparam int AW  = $clog2(FONT_BYTES);
	localparam int MW  = $clog2(FONT_BYTES + 1);
	localparam int RW  = (MW > sgr_pkg::ADDR_W) ? MW : sgr_pkg::ADDR_W;
	localparam int KS  = red_shift(FONT_BYTES);
	localparam int CW  = (KS > 0) ? $clog2(KS + 1) : 1;
	localparam int WCW = $clog2(MAX_GLYPH_WIDTH + 1);
	localparam int PW  = sgr_pkg::CODE_W + sgr_pkg::GW_W;
	localparam int YW  = 2 * sgr_pkg::SCALE_W;

	logic [sgr_pkg::DATA_W-1:0] mem [FONT_BYTES];

	logic                          act_q;
	logic [sgr_pkg::DATA_W-1:0]    data_q;
	logic [7:0]                    ox_q;
	logic [sgr_pkg::SCALE_W-1:0]   sc_q;
	logic [RW-1:0]                 red_q;
	logic [CW-1:0]                 red_cnt_q;
	logic [AW-1:0]                 addr_q;
	logic [WCW-1:0]                cols_q;
	logic [sgr_pkg::COORD_W-1:0]   x_q;
	logic [sgr_pkg::COORD_W-1:0]   y_q;
	logic [2:0]                    bit_q;
	logic [sgr_pkg::DATA_W-1:0]    rdata_q;
	logic [sgr_pkg::COORD_W-1:0]   hold_x_q;
	logic [sgr_pkg::COORD_W-1:0]   hold_y_q;
	logic                          hold_valid_q;
	logic                          out_valid_q;
	sgr_pkg::out_item_t            out_q;

	logic [sgr_pkg::GW_W-1:0]      w_eff;
	logic [sgr_pkg::CODE_W-1:0]    code_off;
	logic [PW-1:0]                 base_full;
	logic [YW-1:0]                 y_off;
	logic [sgr_pkg::COORD_W-1:0]   y_start;
	logic [RW-1:0]                 red_mod;
	logic [RW-1:0]                 red_nxt;
	logic [sgr_pkg::COORD_W-1:0]   sc_ext;

	assign w_eff = (cfg.glyph_width > sgr_pkg::GW_W'(MAX_GLYPH_WIDTH))
		? sgr_pkg::GW_W'(MAX_GLYPH_WIDTH) : cfg.glyph_width;
	assign code_off  = req.char_code - cfg.first_code;
	assign base_full = PW'(code_off) * PW'(w_eff);
	assign y_off     = YW'(w_eff - 1'b1) * YW'(req.scale);
	assign y_start   = sgr_pkg::COORD_W'(req.origin_y) + sgr_pkg::COORD_W'(y_off);
	assign red_mod   = RW'(FONT_BYTES) << red_cnt_q;
	assign red_nxt   = (red_q >= red_mod) ? (red_q - red_mod) : red_q;
	assign sc_ext    = sgr_pkg::COORD_W'(sc_q);

	assign sts.req_load   = (req.action == sgr_pkg::ACT_LOAD);
	assign sts.draw_ok    = (req.char_code >= cfg.first_code) &&
		(req.char_code <= cfg.last_code) && (w_eff != '0);
	assign sts.is_load    = (act_q == sgr_pkg::ACT_LOAD);
	assign sts.red_last   = (red_cnt_q == '0);
	assign sts.bit_set    = rdata_q[bit_q];
	assign sts.bit_last   = (bit_q == sgr_pkg::BIT_LAST);
	assign sts.cols_more  = (cols_q != '0);
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = !out_valid_q || !sq_stall;

	assign sq_valid = out_valid_q;
	assign sq       = out_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_write) begin
			mem[AW'(red_q)] <= data_q;
		end
		if (cmd.mem_read) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_cnt_q    <= '0;
			cols_q       <= '0;
			bit_q        <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				red_cnt_q <= CW'(KS);
				cols_q    <= WCW'(w_eff);
			end else if (cmd.red_step && !sts.red_last) begin
				red_cnt_q <= red_cnt_q - 1'b1;
			end
			if (cmd.mem_read) begin
				cols_q <= cols_q - 1'b1;
				bit_q  <= '0;
			end else if (cmd.scan_adv) begin
				bit_q <= bit_q + 1'b1;
			end
			if (cmd.hold_load) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.hold_clear) begin
				hold_valid_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!sq_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= req.action;
			data_q <= req.load_data;
			ox_q   <= req.origin_x;
			sc_q   <= req.scale;
			y_q    <= y_start;
			red_q  <= (req.action == sgr_pkg::ACT_LOAD) ? RW'(req.load_address)
				: RW'(base_full[sgr_pkg::ADDR_W-1:0]);
		end else if (cmd.red_step) begin
			red_q <= red_nxt;
			if (sts.red_last) begin
				addr_q <= AW'(red_nxt);
			end
		end
		if (cmd.mem_read) begin
			addr_q <= (addr_q == AW'(FONT_BYTES - 1)) ? '0 : addr_q + 1'b1;
			x_q    <= sgr_pkg::COORD_W'(ox_q);
		end else if (cmd.scan_adv) begin
			x_q <= x_q + sc_ext;
			// Step up one column position once the byte is done.
			if (sts.bit_last) begin
				y_q <= y_q - sc_ext;
			end
		end
		if (cmd.hold_load) begin
			hold_x_q <= x_q;
			hold_y_q <= y_q;
		end
		if (cmd.out_load) begin
			out_q.square_x    <= hold_x_q;
			out_q.square_y    <= hold_y_q;
			out_q.square_size <= sc_q;
			out_q.last        <= cmd.out_last;
		end
	end

endmodule

// File: rtl/sideways_glyph_rasterizer_unit.sv
// A load request holds the request port through the modulo reduction of the font
// address (one step at 2048 font bytes) and the memory write.
// A draw holds it through the reduction and, per column, one memory read plus eight bit
// steps, then a flush of the held square; a stalled square output can hold the scan.
// Squares leave one per bit step at most; a code out of range is accepted and dropped.
// Reset clears control state and the registers to their defaults; font memory is kept.
module sideways_glyph_rasterizer_unit #(
	parameter int FONT_BYTES      = 2048,
	parameter int MAX_GLYPH_WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  sgr_pkg::in_item_t          req,
	output logic                       sq_valid,
	input  logic                       sq_stall,
	output sgr_pkg::out_item_t         sq,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sgr_pkg::APB_AW-1:0] paddr,
	input  logic [sgr_pkg::APB_DW-1:0] pwdata,
	output logic [sgr_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	sgr_pkg::cfg_t     cfg;
	sgr_pkg::ctl_cmd_t cmd;
	sgr_pkg::ctl_sts_t sts;

	sgr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sgr_dpath #(
		.FONT_BYTES      (FONT_BYTES),
		.MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg      (cfg),
		.sq_valid (sq_valid),
		.sq_stall (sq_stall),
		.sq       (sq)
	);

endmodule

// File: rtl/sgr_checker.sv
// Port-level checks for the rasterizer, bound to the top level.
module sgr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input sgr_pkg::in_item_t  req,
	input logic               sq_valid,
	input logic               sq_stall,
	input sgr_pkg::out_item_t sq
);

	// A load request always occupies the block for at least the next cycle.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.action == sgr_pkg::ACT_LOAD) |=> req_stall)
		else $error("load request did not hold the request port");

	// A square that is not the last one means the character is still being drawn.
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && !sq.last |-> req_stall)
		else $error("request accepted before the last square of a character");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && sq_stall |=> sq_valid && $stable(sq))
		else $error("stalled square changed or dropped");

endmodule

bind sideways_glyph_rasterizer_unit sgr_checker u_sgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.sq_valid  (sq_valid),
	.sq_stall  (sq_stall),
	.sq        (sq)
);

// File: tb/tb_top.sv
// Self-checking testbench for the sideways glyph rasterizer: font loads, draws and register settings.
`timescale 1ns / 1ps

module tb_top;

	localparam int FONT_DEPTH  = 2048;
	localparam int FONT_AW     = $clog2(FONT_DEPTH);
	localparam int MAX_COLUMNS = 8;
	localparam int SETTLE      = 150;
	localparam int STUCK_LIMIT = 4000;
	localparam int PHASES      = 8;

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_stall;
	sgr_pkg::in_item_t           req;
	logic                        sq_valid;
	logic                        sq_stall;
	sgr_pkg::out_item_t          sq;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sgr_pkg::APB_AW-1:0]  paddr;
	logic [sgr_pkg::APB_DW-1:0]  pwdata;
	logic [sgr_pkg::APB_DW-1:0]  prdata;
	logic                        pready;

	// requests waiting to be driven, squares waiting to come out
	sgr_pkg::in_item_t           request_q[$];
	sgr_pkg::out_item_t          pending_squares[$];

	// mirror of the block: font memory and register settings
	logic [7:0]                  font_copy [0:FONT_DEPTH-1];
	bit                          glyph_loaded [0:FONT_DEPTH-1];
	logic [sgr_pkg::GW_W-1:0]    cfg_width;
	logic [sgr_pkg::CODE_W-1:0]  cfg_first;
	logic [sgr_pkg::CODE_W-1:0]  cfg_last;

	int unsigned         queued_cnt;
	int unsigned         accepted_cnt;
	int unsigned         load_cnt;
	int unsigned         draw_cnt;
	int unsigned         square_cnt;
	int unsigned         error_cnt;
	int unsigned         gap_left;
	int unsigned         stall_left;
	int unsigned         stuck_cycles;
	bit                  req_calm;
	bit                  sq_calm;

	sideways_glyph_rasterizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.sq_valid  (sq_valid),
		.sq_stall  (sq_stall),
		.sq        (sq),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Expected squares of one request, in scan order: columns first, bit 0 upward.
	task automatic rasterize_request(input sgr_pkg::in_item_t rq);
		int unsigned        w;
		int unsigned        base;
		int unsigned        col;
		int unsigned        b;
		int unsigned        total;
		int unsigned        n;
		int unsigned        px;
		int unsigned        py;
		logic [7:0]         column;
		sgr_pkg::out_item_t sqe;
		if (rq.action == sgr_pkg::ACT_LOAD) begin
			font_copy[rq.load_address] = rq.load_data;
			load_cnt++;
		end else begin
			draw_cnt++;
			if (rq.char_code >= cfg_first && rq.char_code <= cfg_last) begin
				w = (cfg_width > MAX_COLUMNS) ? MAX_COLUMNS : cfg_width;
				base = (rq.char_code - cfg_first) * w;
				total = 0;
				for (col = 0; col < w; col++) begin
					column = font_copy[FONT_AW'((base + col) % FONT_DEPTH)];
					for (b = 0; b < 8; b++)
						if (column[b])
							total++;
				end
				n = 0;
				for (col = 0; col < w; col++) begin
					column = font_copy[FONT_AW'((base + col) % FONT_DEPTH)];
					for (b = 0; b < 8; b++) begin
						if (column[b]) begin
							n++;
							px = rq.origin_x + b * rq.scale;
							py = rq.origin_y + (w - 1 - col) * rq.scale;
							sqe.square_x    = px[sgr_pkg::COORD_W-1:0];
							sqe.square_y    = py[sgr_pkg::COORD_W-1:0];
							sqe.square_size = rq.scale;
							sqe.last        = (n == total);
							pending_squares.push_back(sqe);
						end
					end
				end
			end
		end
	endtask

	// Request driver: hold while stalled, then wait the drawn gap before the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			gap_left   = 0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) begin
				rasterize_request(req);
				accepted_cnt++;
				gap_left = req_calm ? 0 : $urandom_range(0, 15);
			end
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (request_q.size() > 0) begin
				req       <= request_q.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Square monitor: compare against the oldest expectation, then stall a drawn while.
	always @(posedge clk or negedge arst_n) begin
		sgr_pkg::out_item_t want;
		if (!arst_n) begin
			sq_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (sq_valid && !sq_stall) begin
				if (pending_squares.size() == 0) begin
					error_cnt++;
					if (error_cnt <= 10)
						$display("unexpected square x=%0d y=%0d size=%0d last=%0b",
							sq.square_x, sq.square_y, sq.square_size, sq.last);
				end else begin
					want = pending_squares.pop_front();
					square_cnt++;
					if (sq.square_x !== want.square_x || sq.square_y !== want.square_y ||
						sq.square_size !== want.square_size || sq.last !== want.last) begin
						error_cnt++;
						if (error_cnt <= 10) begin
							$display("square %0d: expected x=%0d y=%0d size=%0d last=%0b,",
								square_cnt, want.square_x, want.square_y,
								want.square_size, want.last);
							$display("  got x=%0d y=%0d size=%0d last=%0b",
								sq.square_x, sq.square_y, sq.square_size, sq.last);
						end
					end
				end
				stall_left = sq_calm ? 0 : $urandom_range(0, 15);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			sq_stall <= (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (sq_valid && !sq_stall) || (psel && penable))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no progress for %0d cycles", STUCK_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
		logic [7:0] stored;
		stored = (idx == sgr_pkg::REG_GLYPH_WIDTH) ? 8'(val[sgr_pkg::GW_W-1:0]) : val;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			sgr_pkg::REG_GLYPH_WIDTH: cfg_width = val[sgr_pkg::GW_W-1:0];
			sgr_pkg::REG_FIRST_CODE:  cfg_first = val;
			sgr_pkg::REG_LAST_CODE:   cfg_last  = val;
			default: ;
		endcase
		// the address is still on the bus, so read the register back
		@(posedge clk);
		if (prdata !== {24'd0, stored}) begin
			error_cnt++;
			if (error_cnt <= 10)
				$display("register %0d: expected %0d, got %0d", idx, stored, prdata);
		end
	endtask

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		else if (r == 1)
			return 8'hFF;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_origin();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		else if (r == 1)
			return 8'd255;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_load(input int unsigned addr, input logic [7:0] data);
		logic [63:0]       rnd;
		sgr_pkg::in_item_t it;
		rnd = {$urandom, $urandom};
		it = rnd[$bits(sgr_pkg::in_item_t)-1:0];
		it.action       = sgr_pkg::ACT_LOAD;
		it.load_address = addr[sgr_pkg::ADDR_W-1:0];
		it.load_data    = data;
		glyph_loaded[FONT_AW'(addr % FONT_DEPTH)] = 1'b1;
		request_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic push_draw(input logic [7:0] code, input logic [7:0] ox,
		input logic [7:0] oy, input logic [3:0] scl);
		logic [63:0]       rnd;
		sgr_pkg::in_item_t it;
		rnd = {$urandom, $urandom};
		it = rnd[$bits(sgr_pkg::in_item_t)-1:0];
		it.action    = sgr_pkg::ACT_DRAW;
		it.char_code = code;
		it.origin_x  = ox;
		it.origin_y  = oy;
		it.scale     = scl;
		request_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic push_glyph(input logic [7:0] code, input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2, input logic [7:0] c3, input logic [7:0] c4);
		int unsigned base;
		base = (code - cfg_first) * 5;
		push_load(base, c0);
		push_load(base + 1, c1);
		push_load(base + 2, c2);
		push_load(base + 3, c3);
		push_load(base + 4, c4);
	endtask

	// Either load one random font byte, or load any glyph column not yet written (sometimes rewrite), then draw it.
	task automatic push_sequence();
		int unsigned r;
		int unsigned w;
		int unsigned base;
		int unsigned col;
		logic [7:0]  code;
		logic [3:0]  scl;
		bit          blank;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			push_load($urandom_range(0, FONT_DEPTH - 1), pick_byte());
		end else begin
			if (r < 30 || cfg_first > cfg_last)
				code = 8'($urandom_range(0, 255));
			else
				code = 8'($urandom_range(cfg_last, cfg_first));
			if (code >= cfg_first && code <= cfg_last) begin
				w = (cfg_width > MAX_COLUMNS) ? MAX_COLUMNS : cfg_width;
				base = (code - cfg_first) * w;
				blank = ($urandom_range(0, 9) == 0);
				for (col = 0; col < w; col++)
					if (!glyph_loaded[FONT_AW'(base + col)] || blank ||
						$urandom_range(0, 3) == 0)
						push_load(base + col, blank ? 8'h00 : pick_byte());
			end
			if ($urandom_range(0, 99) < 15)
				scl = 4'($urandom_range(0, 15));
			else
				scl = 4'($urandom_range(1, 8));
			push_draw(code, pick_origin(), pick_origin(), scl);
		end
	endtask

	task automatic push_directed();
		push_glyph(8'd32, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_draw(8'd32, 8'd255, 8'd255, 4'd15);
		push_glyph(8'd126, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h81);
		push_draw(8'd126, 8'd0, 8'd0, 4'd1);
		push_glyph(8'd65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_draw(8'd65, 8'd10, 8'd20, 4'd3);
		// codes just outside the range and at the ends of the byte
		push_draw(8'd31, 8'd40, 8'd40, 4'd2);
		push_draw(8'd127, 8'd40, 8'd40, 4'd2);
		push_draw(8'd0, 8'd0, 8'd0, 4'd1);
		push_draw(8'd255, 8'd255, 8'd255, 4'd8);
		push_draw(8'd32, 8'd100, 8'd100, 4'd0);
		push_draw(8'd126, 8'd200, 8'd17, 4'd8);
		push_load(FONT_DEPTH - 1, 8'hA5);
	endtask

	task automatic phase_plan(input int ph, output logic [7:0] w, output logic [7:0] f,
		output logic [7:0] l, output int unsigned n);
		case (ph)
			0: begin w = 8'd5;  f = 8'd32;  l = 8'd126; n = 20; end
			1: begin w = 8'd8;  f = 8'd0;   l = 8'd255; n = 40; end
			2: begin w = 8'd1;  f = 8'd200; l = 8'd210; n = 20; end
			3: begin w = 8'd15; f = 8'd10;  l = 8'd40;  n = 25; end
			4: begin w = 8'd0;  f = 8'd0;   l = 8'd255; n = 12; end
			5: begin w = 8'd3;  f = 8'd100; l = 8'd50;  n = 12; end
			6: begin w = 8'd7;  f = 8'd255; l = 8'd255; n = 15; end
			default: begin w = 8'd5; f = 8'd32; l = 8'd126; n = 15; end
		endcase
	endtask

	initial begin
		int          ph;
		int unsigned i;
		int unsigned start;
		int unsigned budget;
		logic [7:0]  w;
		logic [7:0]  f;
		logic [7:0]  l;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		req_calm = 1'b0;
		sq_calm  = 1'b0;
		queued_cnt   = 0;
		accepted_cnt = 0;
		load_cnt     = 0;
		draw_cnt     = 0;
		square_cnt   = 0;
		error_cnt    = 0;
		stuck_cycles = 0;
		cfg_width = sgr_pkg::GLYPH_WIDTH_RST;
		cfg_first = sgr_pkg::FIRST_CODE_RST;
		cfg_last  = sgr_pkg::LAST_CODE_RST;
		for (i = 0; i < FONT_DEPTH; i++) begin
			font_copy[FONT_AW'(i)]    = 8'h00;
			glyph_loaded[FONT_AW'(i)] = 1'b0;
		end
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);

		for (ph = 0; ph < PHASES; ph++) begin
			phase_plan(ph, w, f, l, budget);
			if (ph > 0) begin
				cfg_write(sgr_pkg::REG_GLYPH_WIDTH, w);
				cfg_write(sgr_pkg::REG_FIRST_CODE, f);
				cfg_write(sgr_pkg::REG_LAST_CODE, l);
			end
			req_calm = ($urandom_range(0, 3) == 0);
			sq_calm  = ($urandom_range(0, 3) == 0);
			if (ph == 0)
				push_directed();
			start = queued_cnt;
			while (queued_cnt - start < budget)
				push_sequence();
			// drain, then let a silent draw finish before touching the registers
			while (accepted_cnt != queued_cnt || pending_squares.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end

		$display("Covered %0d font loads and %0d draws over %0d register settings,",
			load_cnt, draw_cnt, PHASES);
		$display("with %0d squares checked and %0d errors.", square_cnt, error_cnt);
		if (error_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
